// File: rtl/rbbol_pkg.sv
// shared types and constants for the ring buffer byte offset lookup block
// no dependencies; used by rbbol_ram users and the top level
package rbbol_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 16;
    localparam int OFS_W    = 20;
    localparam int REC_W    = HANDLE_W + LEN_W;
    localparam int OUT_IDX_W = 4;
    // running byte total over a full ring
    localparam int SUM_W    = LEN_W + IDX_W;
    localparam int ACC_W    = (SUM_W > OFS_W) ? SUM_W : OFS_W;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_FIND = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_WALK
    } t_state;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(ENTRIES - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

endpackage

// File: rtl/rbbol_ram.sv
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
module rbbol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ring_buffer_byte_offset_lookup_top.sv
// ring buffer byte offset lookup top: ring of handle/length records kept in one record ram
// add: busy while in S_ADD, which writes the record and registers the strobe, so a new
// transfer can be accepted while the strobe shows; find: one stored record walked per cycle
// through the single ram read port, oldest first, busy until the walk settles on the
// hit record or the newest one; a find on an empty ring strobes next cycle and never
// raises busy; receiver cannot stall; synchronous active-low reset clears the write and
// oldest indexes, full flag, sequencer and strobe; record ram is not cleared, only written
// entries are ever used; depends on rbbol_pkg and rbbol_ram
module ring_buffer_byte_offset_lookup_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_entry_handle,
    input  logic [15:0] i_entry_length,
    input  logic [19:0] i_byte_offset,
    output logic        o_result_valid,
    output logic        o_found,
    output logic [3:0]  o_record_index,
    output logic [31:0] o_record_handle,
    output logic [15:0] o_byte_in_record,
    output logic        o_evicted_valid,
    output logic [31:0] o_evicted_handle
);

    localparam int IDX_W = rbbol_pkg::IDX_W;
    localparam int ACC_W = rbbol_pkg::ACC_W;

    // sequencer and ring pointers
    rbbol_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]  r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]  r_old_idx, n_old_idx;
    logic              r_full, n_full;

    // walk state: slot whose data arrives this cycle, next slot to read, end-of-ring flag
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_last, n_last;
    logic [ACC_W-1:0]  r_acc, n_acc;

    // latched item
    logic [31:0]       r_handle, n_handle;
    logic [15:0]       r_length, n_length;
    logic [19:0]       r_offset, n_offset;

    // result registers
    logic              r_res_valid, n_res_valid;
    logic              r_found, n_found;
    logic [3:0]        r_rec_idx, n_rec_idx;
    logic [31:0]       r_rec_handle, n_rec_handle;
    logic [15:0]       r_byte_in, n_byte_in;
    logic              r_ev_valid, n_ev_valid;
    logic [31:0]       r_ev_handle, n_ev_handle;

    // record ram ports
    logic                        ram_wr_en;
    logic [IDX_W-1:0]            ram_rd_addr;
    logic [rbbol_pkg::REC_W-1:0] ram_wr_data;
    logic [rbbol_pkg::REC_W-1:0] ram_rd_data;

    logic              accept;
    logic              ring_empty;
    logic [31:0]       rd_handle;
    logic [15:0]       rd_length;
    logic [ACC_W-1:0]  walk_end;
    logic              hit;
    logic [IDX_W-1:0]  old_next;
    logic [IDX_W-1:0]  wr_next;
    logic [IDX_W-1:0]  idx_next;

    assign accept     = start && !busy;
    assign ring_empty = !r_full && (r_wr_idx == r_old_idx);
    assign rd_handle  = ram_rd_data[rbbol_pkg::REC_W-1 -: rbbol_pkg::HANDLE_W];
    assign rd_length  = ram_rd_data[rbbol_pkg::LEN_W-1:0];
    // end of the current record in the joined byte string
    assign walk_end   = r_acc + ACC_W'(rd_length);
    assign hit        = walk_end > ACC_W'(r_offset);
    assign old_next   = rbbol_pkg::next_slot(r_old_idx);
    assign wr_next    = rbbol_pkg::next_slot(r_wr_idx);
    assign idx_next   = rbbol_pkg::next_slot(r_idx);

    rbbol_ram #(
        .WIDTH (rbbol_pkg::REC_W),
        .DEPTH (rbbol_pkg::ENTRIES)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbbol_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_func == rbbol_pkg::FUNC_ADD) begin
                        n_state = rbbol_pkg::S_ADD;
                    end else if (!ring_empty) begin
                        n_state = rbbol_pkg::S_WALK;
                    end
                end
            end
            rbbol_pkg::S_ADD: begin
                n_state = rbbol_pkg::S_IDLE;
            end
            rbbol_pkg::S_WALK: begin
                if (hit || r_last) begin
                    n_state = rbbol_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rbbol_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_wr_idx     = r_wr_idx;
        n_old_idx    = r_old_idx;
        n_full       = r_full;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_last       = r_last;
        n_acc        = r_acc;
        n_handle     = r_handle;
        n_length     = r_length;
        n_offset     = r_offset;
        n_res_valid  = 1'b0;
        n_found      = r_found;
        n_rec_idx    = r_rec_idx;
        n_rec_handle = r_rec_handle;
        n_byte_in    = r_byte_in;
        n_ev_valid   = r_ev_valid;
        n_ev_handle  = r_ev_handle;
        ram_wr_en    = 1'b0;
        ram_wr_data  = {r_handle, r_length};
        ram_rd_addr  = r_idx;
        busy         = 1'b1;

        unique case (r_state)
            rbbol_pkg::S_IDLE: begin
                busy = 1'b0;
                // add reads the slot about to be overwritten, find reads the oldest slot
                ram_rd_addr = (i_func == rbbol_pkg::FUNC_ADD) ? r_wr_idx : r_old_idx;
                if (accept) begin
                    n_handle = i_entry_handle;
                    n_length = i_entry_length;
                    n_offset = i_byte_offset;
                    n_cur    = r_old_idx;
                    n_idx    = old_next;
                    n_last   = (old_next == r_wr_idx);
                    n_acc    = '0;
                    if (i_func == rbbol_pkg::FUNC_FIND && ring_empty) begin
                        // nothing stored: answer straight away
                        n_res_valid  = 1'b1;
                        n_found      = 1'b0;
                        n_rec_idx    = '0;
                        n_rec_handle = '0;
                        n_byte_in    = '0;
                        n_ev_valid   = 1'b0;
                        n_ev_handle  = '0;
                    end
                end
            end
            rbbol_pkg::S_ADD: begin
                ram_wr_en    = 1'b1;
                n_wr_idx     = wr_next;
                if (r_full) begin
                    n_old_idx = wr_next;
                end else if (wr_next == r_old_idx) begin
                    n_full = 1'b1;
                end
                n_res_valid  = 1'b1;
                n_found      = 1'b0;
                n_rec_idx    = '0;
                n_rec_handle = '0;
                n_byte_in    = '0;
                n_ev_valid   = r_full;
                n_ev_handle  = r_full ? rd_handle : 32'd0;
            end
            rbbol_pkg::S_WALK: begin
                if (hit) begin
                    n_res_valid  = 1'b1;
                    n_found      = 1'b1;
                    n_rec_idx    = 4'(r_cur);
                    n_rec_handle = rd_handle;
                    n_byte_in    = 16'(ACC_W'(r_offset) - r_acc);
                    n_ev_valid   = 1'b0;
                    n_ev_handle  = '0;
                end else if (r_last) begin
                    // offset past the stored bytes
                    n_res_valid  = 1'b1;
                    n_found      = 1'b0;
                    n_rec_idx    = '0;
                    n_rec_handle = '0;
                    n_byte_in    = '0;
                    n_ev_valid   = 1'b0;
                    n_ev_handle  = '0;
                end else begin
                    // issue the read of the next record
                    n_acc  = walk_end;
                    n_cur  = r_idx;
                    n_idx  = idx_next;
                    n_last = (idx_next == r_wr_idx);
                end
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbbol_pkg::S_IDLE;
            r_wr_idx    <= '0;
            r_old_idx   <= '0;
            r_full      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_old_idx   <= n_old_idx;
            r_full      <= n_full;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_acc        <= n_acc;
        r_handle     <= n_handle;
        r_length     <= n_length;
        r_offset     <= n_offset;
        r_found      <= n_found;
        r_rec_idx    <= n_rec_idx;
        r_rec_handle <= n_rec_handle;
        r_byte_in    <= n_byte_in;
        r_ev_valid   <= n_ev_valid;
        r_ev_handle  <= n_ev_handle;
    end

    assign o_result_valid   = r_res_valid;
    assign o_found          = r_found;
    assign o_record_index   = r_rec_idx;
    assign o_record_handle  = r_rec_handle;
    assign o_byte_in_record = r_byte_in;
    assign o_evicted_valid  = r_ev_valid;
    assign o_evicted_handle = r_ev_handle;

    // a full ring always has oldest and write pointers together
    a_full_ptrs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_old_idx == r_wr_idx))
        else $error("full ring with split pointers");

    // an accepted transfer either answers next cycle or keeps the block busy
    a_accept_progress : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_result_valid || busy))
        else $error("accepted transfer lost");

    // a result never reports both a hit and an eviction
    a_result_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_found && o_evicted_valid))
        else $error("result mixes find and add fields");

    // the ram is written only while an add completes
    a_write_in_add : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |=> (o_result_valid && !o_found))
        else $error("record write outside an add");

endmodule
